@@ hdl/dsr_pkg.sv @@
// shared types and field widths for the dfa string recognizer
package dsr_pkg;

	localparam int KIND_W     = 2;
	localparam int IDX_W      = 4;
	localparam int SYM_W      = 8;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_W      = 4;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_FINAL  = 2'd1,
		KIND_FEED   = 2'd2,
		KIND_FINISH = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_META,
		ST_SEARCH
	} fsm_t;

endpackage

@@ hdl/dsr_ram.sv @@
// generic single-port-write ram with registered read
module dsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/dsr_meta_store.sv @@
// per-state final mark and list count store, entries read as zero until written
module dsr_meta_store #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [DEPTH-1:0] vld_q;
	logic             vld_s1;
	logic [WIDTH-1:0] ram_rd_data;

	dsr_ram #(
		.WIDTH(WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = vld_s1 ? ram_rd_data : '0;

endmodule

@@ hdl/dfa_string_recognizer_core.sv @@
// top level of the programmable dfa string recognizer
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: kind; tdata: state_index, symbol, target_state,
//                                   final_flag
//  m_*      out  m_tvalid/m_tready  tdata: accepted, status
//  cfg_*    in   cfg_we             cfg_wdata: initial_state
//
// add transition, set final flag and finish string are handled as the accept, then
// the mark and count read. feed symbol follows these with a search of the stored
// transitions (up to EDGES_PER_STATE), one edge store read per cycle while the output is free.
// reset clears marks and counts at once through valid bits, no clearing pass.
// a result still waiting on m_tready holds the next request in its mark and count read cycle.
module dfa_string_recognizer_core #(
	parameter int NUM_STATES      = 16,
	parameter int EDGES_PER_STATE = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [16] final_flag, [15:12] target_state, [11:4] symbol, [3:0] state_index
	input  logic [dsr_pkg::IN_DATA_W-1:0]     s_tdata,
	// [1:0] kind
	input  logic [dsr_pkg::KIND_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [1] status, [0] accepted
	output logic [dsr_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_we,
	input  logic [dsr_pkg::CFG_W-1:0]         cfg_wdata
);

	import dsr_pkg::*;

	localparam int SW  = $clog2(NUM_STATES);
	localparam int CW  = $clog2(EDGES_PER_STATE + 1);
	localparam int D   = NUM_STATES * EDGES_PER_STATE;
	localparam int AW  = $clog2(D);
	localparam int EDW = SYM_W + SW;
	localparam int MW  = CW + 1;

	function automatic logic [16*SW-1:0] fold_table();
		logic [16*SW-1:0] t;
		int               r;
		t = '0;
		r = 0;
		for (int i = 0; i < 16; i++) begin
			t[i*SW +: SW] = SW'(r);
			r = (r == NUM_STATES - 1) ? 0 : r + 1;
		end
		return t;
	endfunction

	localparam logic [16*SW-1:0] FOLD_TAB = fold_table();

	function automatic logic [SW-1:0] fold(input logic [IDX_W-1:0] v);
		return FOLD_TAB[v*SW +: SW];
	endfunction

	function automatic logic [AW-1:0] base(input logic [SW-1:0] st);
		return AW'(AW'(st) * AW'(EDGES_PER_STATE));
	endfunction

	fsm_t            state_q, state_nxt;
	kind_t           kind_q;
	logic [SW-1:0]   idx_q;
	logic [SYM_W-1:0] sym_q;
	logic [SW-1:0]   tgt_q;
	logic            flag_q;
	logic [SW-1:0]   cur_q;
	logic            sink_q;
	logic [SW-1:0]   init_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   j_q;
	logic            out_valid_q;
	logic            acc_q;
	logic            status_q;

	kind_t           s_kind;
	logic            accept;
	logic            out_free;

	logic            meta_rd_en;
	logic [SW-1:0]   meta_rd_addr;
	logic            meta_wr_en;
	logic [SW-1:0]   meta_wr_addr;
	logic [MW-1:0]   meta_wr_data;
	logic [MW-1:0]   meta_rd_data;
	logic [CW-1:0]   meta_cnt;
	logic            meta_mark;
	logic            list_full;

	logic            edge_rd_en;
	logic [AW-1:0]   edge_rd_addr;
	logic            edge_wr_en;
	logic [AW-1:0]   edge_wr_addr;
	logic [EDW-1:0]  edge_wr_data;
	logic [EDW-1:0]  edge_rd_data;
	logic [SYM_W-1:0] edge_label;
	logic [SW-1:0]   edge_target;
	logic            hit;
	logic [CW-1:0]   j_nxt;
	logic            j_last;

	logic            res_en;
	logic            res_acc;
	logic            res_status;
	logic            cur_ld;
	logic [SW-1:0]   cur_val;
	logic            sink_set;
	logic            sink_clr;
	logic            search_start;
	logic            j_inc;

	dsr_meta_store #(
		.WIDTH(MW),
		.DEPTH(NUM_STATES)
	) u_meta (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (meta_wr_en),
		.wr_addr(meta_wr_addr),
		.wr_data(meta_wr_data),
		.rd_en  (meta_rd_en),
		.rd_addr(meta_rd_addr),
		.rd_data(meta_rd_data)
	);

	dsr_ram #(
		.WIDTH(EDW),
		.DEPTH(D)
	) u_edges (
		.clk    (clk),
		.wr_en  (edge_wr_en),
		.wr_addr(edge_wr_addr),
		.wr_data(edge_wr_data),
		.rd_en  (edge_rd_en),
		.rd_addr(edge_rd_addr),
		.rd_data(edge_rd_data)
	);

	assign s_kind      = kind_t'(s_tuser);
	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign out_free    = !out_valid_q || m_tready;
	assign meta_cnt    = meta_rd_data[CW-1:0];
	assign meta_mark   = meta_rd_data[CW];
	assign list_full   = (meta_cnt >= CW'(EDGES_PER_STATE));
	assign edge_label  = edge_rd_data[EDW-1:SW];
	assign edge_target = edge_rd_data[SW-1:0];
	assign hit         = (edge_label == sym_q);
	assign j_nxt       = j_q + CW'(1);
	assign j_last      = (j_nxt == cnt_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_META;
				end
			end
			ST_META: begin
				if (out_free) begin
					if (kind_q == KIND_FEED && !sink_q && meta_cnt != '0) begin
						state_nxt = ST_SEARCH;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_SEARCH: begin
				if (out_free && (hit || j_last)) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// memory accesses and result decisions
	always_comb begin
		meta_rd_en   = 1'b0;
		meta_rd_addr = cur_q;
		meta_wr_en   = 1'b0;
		meta_wr_addr = idx_q;
		meta_wr_data = {meta_mark, meta_cnt};
		edge_rd_en   = 1'b0;
		edge_rd_addr = base(cur_q) + AW'(j_nxt);
		edge_wr_en   = 1'b0;
		edge_wr_addr = base(idx_q) + AW'(meta_cnt);
		edge_wr_data = {sym_q, tgt_q};
		res_en       = 1'b0;
		res_acc      = 1'b0;
		res_status   = 1'b0;
		cur_ld       = 1'b0;
		cur_val      = init_q;
		sink_set     = 1'b0;
		sink_clr     = 1'b0;
		search_start = 1'b0;
		j_inc        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				meta_rd_en = accept;
				if (s_kind == KIND_ADD || s_kind == KIND_FINAL) begin
					meta_rd_addr = fold(s_tdata[IDX_W-1:0]);
				end
			end
			ST_META: begin
				if (out_free) begin
					case (kind_q)
						KIND_ADD: begin
							res_en = 1'b1;
							if (list_full) begin
								res_status = 1'b1;
							end else begin
								edge_wr_en   = 1'b1;
								meta_wr_en   = 1'b1;
								meta_wr_data = {meta_mark, meta_cnt + CW'(1)};
							end
						end
						KIND_FINAL: begin
							res_en       = 1'b1;
							meta_wr_en   = 1'b1;
							meta_wr_data = {flag_q, meta_cnt};
						end
						KIND_FEED: begin
							if (sink_q) begin
								res_en = 1'b1;
							end else if (meta_cnt == '0) begin
								res_en   = 1'b1;
								sink_set = 1'b1;
							end else begin
								edge_rd_en   = 1'b1;
								edge_rd_addr = base(cur_q);
								search_start = 1'b1;
							end
						end
						default: begin
							res_en   = 1'b1;
							res_acc  = !sink_q && meta_mark;
							cur_ld   = 1'b1;
							sink_clr = 1'b1;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				if (out_free) begin
					if (hit) begin
						res_en  = 1'b1;
						cur_ld  = 1'b1;
						cur_val = edge_target;
					end else if (j_last) begin
						res_en   = 1'b1;
						sink_set = 1'b1;
					end else begin
						edge_rd_en = 1'b1;
						j_inc      = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			sink_q      <= 1'b0;
			init_q      <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			j_q         <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				init_q <= fold(cfg_wdata);
				cur_q  <= fold(cfg_wdata);
				sink_q <= 1'b0;
			end else begin
				if (cur_ld) begin
					cur_q <= cur_val;
				end
				if (sink_set) begin
					sink_q <= 1'b1;
				end else if (sink_clr) begin
					sink_q <= 1'b0;
				end
			end
			if (search_start) begin
				cnt_q <= meta_cnt;
				j_q   <= '0;
			end else if (j_inc) begin
				j_q <= j_nxt;
			end
			if (res_en) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request payload and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_kind;
			idx_q  <= fold(s_tdata[3:0]);
			sym_q  <= s_tdata[11:4];
			tgt_q  <= fold(s_tdata[15:12]);
			flag_q <= s_tdata[16];
		end
		if (res_en) begin
			acc_q    <= res_acc;
			status_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, status_q, acc_q};

endmodule
